@@ sv/utt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_pkg: shared types and helpers for the UTF-16 to UTF-8 transcoder
// Holds the job descriptor passed from the front end to the byte sequencer,
// the surrogate tags and the UTF-8 byte encoder.
// ----------------------------------------------------------------------------
package utt_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [5:0] HI_SUR_TAG = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0] LO_SUR_TAG = 6'b110111;  // 0xDC00 >> 10

  // Encoded length minus one
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_3 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Work for one input item: an optional lone high surrogate flushed first,
  // then an optional code point.
  typedef struct packed {
    logic        pre_vld;
    logic [9:0]  pre_pay;
    logic        main_vld;
    logic [20:0] main_cp;
    logic [1:0]  main_len;
  } job_t;

  // Byte number pos of the UTF-8 form of cp, which has len+1 bytes
  function automatic logic [7:0] enc_byte(input logic [20:0] cp,
                                          input logic [1:0] len,
                                          input logic [1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    unique case (len)
      LEN_1: b = {1'b0, cp[6:0]};
      LEN_2: begin
        unique case (pos)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      LEN_3: begin
        unique case (pos)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (pos)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ sv/utt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_front: input classifier
// Accepts code units, pairs surrogates and builds one job per item that
// gives output. A high surrogate that is not the last unit is held here.
// ----------------------------------------------------------------------------
module utt_front import utt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] code_unit
  input  wire logic        in_tlast,   // last_unit
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic       held_r, held_nxt;
  logic [9:0] pay_r, pay_nxt;
  logic       acc, is_hi, is_lo;
  logic [1:0] bmp_len;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign is_hi     = (in_tdata[15:10] == HI_SUR_TAG);
  assign is_lo     = (in_tdata[15:10] == LO_SUR_TAG);

  always_comb begin
    priority if (in_tdata[15:11] != 5'd0) bmp_len = LEN_3;
    else if (in_tdata[15:7] != 9'd0)      bmp_len = LEN_2;
    else                                  bmp_len = LEN_1;
  end

  always_comb begin
    held_nxt       = held_r;
    pay_nxt        = pay_r;
    q_job.pre_vld  = 1'b0;
    q_job.pre_pay  = pay_r;
    q_job.main_vld = 1'b0;
    q_job.main_cp  = {5'd0, in_tdata};
    q_job.main_len = bmp_len;
    if (held_r && is_lo) begin
      // complete the pair
      q_job.main_vld = 1'b1;
      q_job.main_cp  = SUPP_BASE + {1'b0, pay_r, in_tdata[9:0]};
      q_job.main_len = LEN_4;
      held_nxt       = 1'b0;
    end else begin
      // flush a held surrogate alone, then handle the new unit
      q_job.pre_vld = held_r;
      if (is_hi && !in_tlast) begin
        held_nxt = 1'b1;
        pay_nxt  = in_tdata[9:0];
      end else begin
        q_job.main_vld = 1'b1;
        held_nxt       = 1'b0;
      end
    end
  end

  assign q_push = acc && (q_job.pre_vld || q_job.main_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      pay_r  <= 10'd0;
    end else if (acc) begin
      held_r <= held_nxt;
      pay_r  <= pay_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/utt_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_queue: job queue
// Small register FIFO of job descriptors between the classifier and the
// byte sequencer; the head is visible without a pop.
// ----------------------------------------------------------------------------
module utt_queue import utt_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output job_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/utt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utt_back: byte sequencer
// Walks the head job byte by byte into a registered output stage and pops
// the job with its last byte.
// ----------------------------------------------------------------------------
module utt_back import utt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  job_t            q_head,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // char_end
  output logic            out_tlast   // last_of_item
);

  logic        vld_r;
  logic [7:0]  byte_r;
  logic        end_r, last_r;
  logic        seg_r, seg_nxt;     // 0: flushed surrogate, 1: main code point
  logic [1:0]  pos_r, pos_nxt;
  logic        eff_main, seg_last, job_last, fire;
  logic [20:0] cur_cp;
  logic [1:0]  cur_len;

  assign eff_main = seg_r || !q_head.pre_vld;
  assign cur_cp   = eff_main ? q_head.main_cp : {5'd0, HI_SUR_TAG, q_head.pre_pay};
  assign cur_len  = eff_main ? q_head.main_len : LEN_3;
  assign seg_last = (pos_r == cur_len);
  assign job_last = seg_last && (eff_main || !q_head.main_vld);
  assign fire     = !q_empty && (!vld_r || out_tready);
  assign q_pop    = fire && job_last;

  always_comb begin
    seg_nxt = seg_r;
    pos_nxt = pos_r;
    if (fire) begin
      priority if (job_last) begin
        seg_nxt = 1'b0;
        pos_nxt = 2'd0;
      end else if (seg_last) begin
        seg_nxt = 1'b1;
        pos_nxt = 2'd0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      seg_r <= 1'b0;
      pos_r <= 2'd0;
    end else begin
      seg_r <= seg_nxt;
      pos_r <= pos_nxt;
      if (fire) begin
        vld_r <= 1'b1;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_r <= enc_byte(cur_cp, cur_len, pos_r);
      end_r  <= seg_last;
      last_r <= job_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = end_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

@@ sv/utf16_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder: UTF-16 code units in, UTF-8 bytes out
// Input stream: one code unit per item in in_tdata[15:0]; in_tlast marks the
// last unit of a string, and a high surrogate on that unit is encoded alone.
// Output stream: one UTF-8 byte per item in out_tdata[7:0]; out_tuser is high
// on the last byte of a code point, out_tlast on the last byte caused by one
// input unit. A high surrogate waiting for its partner gives no output.
// Path: a unit's job is written into the job queue, and each of its bytes is
// then registered in the output stage.
// Throughput: the output register moves one byte per cycle while a job is
// queued and the receiver is ready. A unit gives 1 to 3 bytes, a completed
// pair 4, up to 6 when a lone surrogate is flushed ahead of a new unit, and
// none for a held high surrogate. A queue of QUEUE_DEPTH jobs lets
// input be taken while earlier bytes are still going out.
// Reset (rst_n low, synchronous): the queue empties, no surrogate is held,
// out_tvalid drops. When the receiver stalls, the output byte holds, the
// queue fills and in_tready goes low.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder import utt_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] code_unit
  input  wire logic        in_tlast,   // last_unit
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tuser,  // char_end
  output logic             out_tlast   // last_of_item
);

  job_t push_job, head_job;
  logic q_push, q_full, q_pop, q_empty;

  utt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  utt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
